[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL. Every check is clocked on clk and
// is switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// A consequence that must hold in the same cycle as its condition.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/core/mbp_pkg.sv]
`default_nettype none

package mbp_pkg;

  // Buffer size limit and the widths that follow from it.
  localparam int MAX_BYTES = 65536;
  localparam int BITPOS_W  = $clog2(MAX_BYTES * 8 + 1);
  localparam int SUM_W     = BITPOS_W + 1;
  localparam int CAPEFF_W  = $clog2(MAX_BYTES + 1);

  // Field widths of the streams and the register.
  localparam int FIELD_W     = 64;
  localparam int WIDTH_W     = 7;
  localparam int KIND_W      = 2;
  localparam int IDX_W       = 16;
  localparam int CAP_W       = 17;
  localparam int IN_TDATA_W  = ((FIELD_W + WIDTH_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 8 + IDX_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(65536);

  // APB register map.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [0:0] REG_CAPACITY = 1'b0;

  // Item kinds carried on the input tuser.
  localparam logic [KIND_W-1:0] KIND_PLAIN   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SIGNMAG = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH   = 2'd2;

  // Packer sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_ALIGN,
    ST_EMIT,
    ST_FLUSH,
    ST_ERROR
  } mbp_state_t;

  // One result item.
  typedef struct packed {
    logic [7:0]       out_byte;
    logic [IDX_W-1:0] byte_index;
    logic             error;
    logic             last;
  } mbp_result_t;

  // Result handed from the packer to the output stage.
  typedef struct packed {
    logic        valid;
    mbp_result_t res;
  } mbp_push_t;

endpackage

`default_nettype wire

[rtl/core/msb_first_bit_packer.sv]
// MSB-first bit packer. Each input transfer is a plain field, a
// sign-magnitude field or a flush; fields are packed first bit into bit 7
// and each byte is sent as soon as it is complete, with its buffer index
// and tlast on the final byte an item causes. A field that would pass the
// capacity register is refused whole and reported by one transfer with
// tuser set. The input is taken only while the packer is idle, but a
// finished byte waits in the output register without holding it up. A field
// is accepted, checked for room and loaded into the shift register, shifted
// a whole byte at a time past the bytes above its top bit, then moved out one
// output byte at a time through a 16-bit window of the shift register. A
// flush is accepted and then sends its padded byte, a refused field is
// accepted, checked and reported, and an item that writes nothing is only
// accepted; a stalled m_tready holds back each step that sends a byte.
`default_nettype none

module msb_first_bit_packer
  import mbp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // Input stream.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // value [63:0], width [70:64], zero [71]
  input  logic [KIND_W-1:0]      s_tuser,   // kind [1:0]
  // Output stream.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // out_byte [7:0], byte_index [23:8]
  output logic [0:0]             m_tuser,   // error [0]
  output logic                   m_tlast,
  // Configuration.
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  logic [CAP_W-1:0] capacity;
  mbp_push_t        push;
  logic             out_space;

  mbp_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  mbp_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .kind      (s_tuser),
    .value     (s_tdata[FIELD_W-1:0]),
    .width     (s_tdata[FIELD_W +: WIDTH_W]),
    .capacity  (capacity),
    .push      (push),
    .out_space (out_space)
  );

  mbp_out u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .out_space (out_space),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire

[rtl/core/mbp_regs.sv]
`default_nettype none

module mbp_regs
  import mbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [CAP_W-1:0]      capacity
);

  logic [APB_ADDR_W-3:0] word_addr;
  logic                  wr_en;

  // The port never inserts wait states.
  assign pready    = 1'b1;
  assign word_addr = paddr[APB_ADDR_W-1:2];
  assign wr_en     = psel & penable & pwrite & pready & (word_addr == REG_CAPACITY);

  // Capacity register, written at the end of the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (wr_en) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  // Read data for the addressed register.
  assign prdata = (word_addr == REG_CAPACITY) ? APB_DATA_W'(capacity) : '0;

endmodule

`default_nettype wire

[rtl/core/mbp_engine.sv]
`default_nettype none

`include "assert_macros.svh"

module mbp_engine
  import mbp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [KIND_W-1:0]  kind,
  input  logic [FIELD_W-1:0] value,
  input  logic [WIDTH_W-1:0] width,
  input  logic [CAP_W-1:0]   capacity,
  output mbp_push_t          push,
  input  logic               out_space
);

  mbp_state_t state, state_next;

  // Item captured at the input transfer.
  logic [KIND_W-1:0]  item_kind;
  logic [FIELD_W-1:0] item_value;
  logic [WIDTH_W-1:0] item_n;
  logic [WIDTH_W-1:0] n_in;

  // Field shift register and its window bookkeeping.
  logic [FIELD_W-1:0] sr, sr_next;
  logic [WIDTH_W-1:0] rem, rem_next;
  logic [2:0]         offs, offs_next;
  logic [2:0]         skip, skip_next;

  // Architectural packer state.
  logic [6:0]          pend_bits, pend_bits_next;
  logic [2:0]          pend_cnt, pend_cnt_next;
  logic [BITPOS_W-1:0] bit_pos, bit_pos_next;

  // Setup of a field: capacity check and sign-magnitude word.
  logic [CAPEFF_W-1:0] cap_eff;
  logic                over;
  logic                neg;
  logic [FIELD_W-1:0]  mag;
  logic [FIELD_W-1:0]  sign_oh;
  logic [FIELD_W-1:0]  word;
  logic [WIDTH_W-1:0]  lead_gap;
  logic [IDX_W-1:0]    idx;

  // Up to a byte per cycle, output allowing, from a 16-bit window of sr.
  logic [3:0]         room;
  logic [3:0]         take;
  logic [15:0]        window;
  logic [7:0]         taken;
  logic [7:0]         acc;
  logic               full;
  logic [WIDTH_W-1:0] rem_after;
  logic [3:0]         offs_sum;
  logic [7:0]         flush_byte;

  assign n_in = (width > WIDTH_W'(FIELD_W)) ? WIDTH_W'(FIELD_W) : width;

  assign cap_eff = (32'(capacity) > 32'(MAX_BYTES)) ? CAPEFF_W'(MAX_BYTES)
                                                    : CAPEFF_W'(capacity);
  assign over    = (SUM_W'(bit_pos) + SUM_W'(item_n)) > SUM_W'({cap_eff, 3'b000});
  assign idx     = IDX_W'(bit_pos >> 3);

  // The sign bit takes the place of the top magnitude bit of the field.
  assign neg      = item_value[FIELD_W-1];
  assign mag      = neg ? (~item_value + FIELD_W'(1)) : item_value;
  assign sign_oh  = FIELD_W'(1) << (item_n - WIDTH_W'(1));
  assign word     = (item_kind == KIND_SIGNMAG) ? ((mag & ~sign_oh) | (neg ? sign_oh : '0))
                                                : item_value;
  assign lead_gap = WIDTH_W'(FIELD_W) - item_n;

  assign room      = 4'd8 - 4'(pend_cnt);
  assign take      = (rem < WIDTH_W'(room)) ? rem[3:0] : room;
  assign window    = sr[FIELD_W-1 -: 16] << offs;
  assign taken     = window[15:8] >> (4'd8 - take);
  assign acc       = ({1'b0, pend_bits} << take) | taken;
  assign full      = (4'(pend_cnt) + take) == 4'd8;
  assign rem_after = rem - WIDTH_W'(take);
  assign offs_sum  = 4'(offs) + take;
  assign flush_byte = {1'b0, pend_bits} << (4'd8 - 4'(pend_cnt));

  // State register and packer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rem       <= '0;
      offs      <= '0;
      skip      <= '0;
      pend_bits <= '0;
      pend_cnt  <= '0;
      bit_pos   <= '0;
    end else begin
      state     <= state_next;
      rem       <= rem_next;
      offs      <= offs_next;
      skip      <= skip_next;
      pend_bits <= pend_bits_next;
      pend_cnt  <= pend_cnt_next;
      bit_pos   <= bit_pos_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    sr <= sr_next;
    if (in_valid && in_ready) begin
      item_kind  <= kind;
      item_value <= value;
      item_n     <= n_in;
    end
  end

  // Sequencer: next state, datapath updates and result pushes.
  always_comb begin
    state_next     = state;
    sr_next        = sr;
    rem_next       = rem;
    offs_next      = offs;
    skip_next      = skip;
    pend_bits_next = pend_bits;
    pend_cnt_next  = pend_cnt;
    bit_pos_next   = bit_pos;
    push           = '0;
    in_ready       = 1'b0;

    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (kind == KIND_FLUSH) begin
            if (pend_cnt != '0) state_next = ST_FLUSH;
          end else if ((kind == KIND_PLAIN || kind == KIND_SIGNMAG) && width != '0) begin
            state_next = ST_PREP;
          end
        end
      end

      // Check room for the field and load it into the shift register.
      ST_PREP: begin
        sr_next   = word;
        rem_next  = item_n;
        skip_next = lead_gap[5:3];
        offs_next = lead_gap[2:0];
        if (over) begin
          state_next = ST_ERROR;
        end else if (lead_gap[5:3] != '0) begin
          state_next = ST_ALIGN;
        end else begin
          state_next = ST_EMIT;
        end
      end

      // Drop whole bytes above the field's first bit.
      ST_ALIGN: begin
        sr_next   = sr << 8;
        skip_next = skip - 3'd1;
        if (skip == 3'd1) state_next = ST_EMIT;
      end

      // Move up to one byte's worth of bits into the pending byte.
      ST_EMIT: begin
        if (!full || out_space) begin
          push.valid          = full;
          push.res.out_byte   = acc;
          push.res.byte_index = idx;
          push.res.error      = 1'b0;
          push.res.last       = rem_after < WIDTH_W'(8);
          bit_pos_next        = bit_pos + BITPOS_W'(take);
          rem_next            = rem_after;
          offs_next           = offs_sum[2:0];
          if (offs_sum[3]) sr_next = sr << 8;
          if (full) begin
            pend_bits_next = '0;
            pend_cnt_next  = '0;
          end else begin
            pend_bits_next = acc[6:0];
            pend_cnt_next  = pend_cnt + take[2:0];
          end
          if (rem_after == '0) state_next = ST_IDLE;
        end
      end

      // Pad the partial byte with zeros and send it.
      ST_FLUSH: begin
        if (out_space) begin
          push.valid          = 1'b1;
          push.res.out_byte   = flush_byte;
          push.res.byte_index = idx;
          push.res.error      = 1'b0;
          push.res.last       = 1'b1;
          bit_pos_next        = bit_pos + BITPOS_W'(4'd8 - 4'(pend_cnt));
          pend_bits_next      = '0;
          pend_cnt_next       = '0;
          state_next          = ST_IDLE;
        end
      end

      // Report a refused field.
      ST_ERROR: begin
        if (out_space) begin
          push.valid          = 1'b1;
          push.res.out_byte   = '0;
          push.res.byte_index = idx;
          push.res.error      = 1'b1;
          push.res.last       = 1'b1;
          state_next          = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  `ASSERT_CLK(a_pend_matches_pos, pend_cnt == bit_pos[2:0], "pending count off bit position")
  `ASSERT_IMPL(a_emit_has_bits, state == ST_EMIT, rem != '0, "emit with no bits left")
  `ASSERT_IMPL(a_align_has_skip, state == ST_ALIGN, skip != '0, "align with nothing to skip")
  `ASSERT_IMPL(a_push_has_space, push.valid, out_space, "result pushed into a full stage")

endmodule

`default_nettype wire

[rtl/core/mbp_out.sv]
`default_nettype none

module mbp_out
  import mbp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  mbp_push_t              push,
  output logic                   out_space,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic [0:0]             m_tuser,
  output logic                   m_tlast
);

  mbp_result_t res;

  // The stage takes a new result when empty or when the held one leaves.
  assign out_space = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) res <= push.res;
  end

  // Pack the held result onto the master side.
  assign m_tdata = {res.byte_index, res.out_byte};
  assign m_tuser = res.error;
  assign m_tlast = res.last;

endmodule

`default_nettype wire
